// ----- rtl/bitmap_first_free_allocator_unit_defines.svh -----
// Assertion macros for the allocator RTL.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold on that edge.
`define BFFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define BFFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define BFFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BFFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/bffa_pkg.sv -----
package bffa_pkg;

    // Map geometry.
    localparam int MAP_BYTES = 1024;
    localparam int BYTE_W    = 8;
    localparam int BIT_SEL_W = 3;
    localparam int IDX_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int FILL_W    = $clog2(MAP_BYTES + 1);
    localparam int MAP_ITEMS = MAP_BYTES * 8;

    // Field widths.
    localparam int LIMIT_W  = 14;
    localparam int INDEX_W  = 13;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 20;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;
    localparam logic [CAP_W-1:0]   ITEM_CAP    = CAP_W'(MAP_ITEMS);
    localparam logic [IDX_W-1:0]   LAST_BYTE   = IDX_W'(MAP_BYTES - 1);
    localparam logic [BYTE_W-1:0]  BYTE_FULL   = 8'hff;
    localparam logic [BYTE_W-1:0]  BYTE_ONE    = 8'h01;
    localparam logic [BYTE_W-1:0]  BYTE_EMPTY  = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    // Result of the shared byte unit.
    typedef struct packed {
        logic                 all_ones;
        logic [BIT_SEL_W-1:0] low_zero;
        logic [BYTE_W-1:0]    set_low;
        logic                 bit_set;
        logic [BYTE_W-1:0]    clr_sel;
    } t_byte_res;

endpackage

// ----- rtl/bffa_map_ram.sv -----
module bffa_map_ram (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [bffa_pkg::IDX_W-1:0]   i_wr_addr,
    input  logic [bffa_pkg::BYTE_W-1:0]  i_wr_data,
    input  logic [bffa_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [bffa_pkg::BYTE_W-1:0]  o_rd_data
);

    logic [bffa_pkg::BYTE_W-1:0] r_mem [bffa_pkg::MAP_BYTES];
    logic [bffa_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/bffa_byte_unit.sv -----
module bffa_byte_unit (
    input  logic [bffa_pkg::BYTE_W-1:0]    i_byte,
    input  logic [bffa_pkg::BIT_SEL_W-1:0] i_bit_sel,
    output bffa_pkg::t_byte_res            o_res
);

    // Lowest clear bit among bits 0..6; bit 7 is taken when those are all set.
    always_comb begin
        logic [bffa_pkg::BIT_SEL_W-1:0] lz;
        lz = 3'd7;
        for (int b = 6; b >= 0; b--) begin
            if (!i_byte[b]) begin
                lz = 3'(b);
            end
        end
        o_res.all_ones = (i_byte == bffa_pkg::BYTE_FULL);
        o_res.low_zero = lz;
        o_res.set_low  = i_byte | (bffa_pkg::BYTE_ONE << lz);
        o_res.bit_set  = i_byte[i_bit_sel];
        o_res.clr_sel  = i_byte & ~(bffa_pkg::BYTE_ONE << i_bit_sel);
    end

endmodule

// ----- rtl/bitmap_first_free_allocator_unit.sv -----
// First-fit bitmap allocator over a map of 1024 bytes (8192 items).
// A request is taken at a rising edge where start is high and busy is low:
// i_func selects allocate (lowest free item) or free (the item in
// i_bit_index). Each request produces exactly one result, shown on
// o_status and o_alloc_index for a single cycle while o_done is high.
// The receiver has no way to hold a result off, so it must sample it then.
// Allocation scans the map one byte per cycle through the single read port
// of the map memory, whose read data is registered, and ends at the first
// byte that is not full, or after the last byte when every byte is full. A free
// request reads the byte of its item and then checks it, or ends without the
// check when its item is at or above the limit. busy drops in the same cycle
// that o_done is shown, so a new request may follow at once.
// The item limit register is written through i_cfg_wr_en/i_cfg_wr_data and
// should only change while the block is idle. Reset returns the limit to
// 8192 and empties the map without a clearing pass: a fill count marks the
// bytes that were ever written, and any byte at or above it reads as zero.
`include "bitmap_first_free_allocator_unit_defines.svh"

module bitmap_first_free_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [bffa_pkg::INDEX_W-1:0]     i_bit_index,
    input  logic                             i_cfg_wr_en,
    input  logic [bffa_pkg::LIMIT_W-1:0]     i_cfg_wr_data,
    output logic                             o_done,
    output logic [bffa_pkg::STATUS_W-1:0]    o_status,
    output logic [bffa_pkg::INDEX_W-1:0]     o_alloc_index
);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN     = 4'b0010,
        ST_FREE_RD  = 4'b0100,
        ST_FREE_CHK = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [bffa_pkg::IDX_W-1:0]      r_addr, n_addr;    // byte being read
    logic [bffa_pkg::IDX_W-1:0]      r_chk, n_chk;      // byte whose data is back
    logic                            r_pend, n_pend;    // read data is valid
    logic [bffa_pkg::INDEX_W-1:0]    r_bidx, n_bidx;    // item of a free request
    logic [bffa_pkg::FILL_W-1:0]     r_fill, n_fill;    // bytes ever written
    logic [bffa_pkg::LIMIT_W-1:0]    r_limit;
    logic                            r_done, n_done;
    bffa_pkg::t_status               r_status, n_status;
    logic [bffa_pkg::INDEX_W-1:0]    r_aidx, n_aidx;

    logic                            wr_en;
    logic [bffa_pkg::BYTE_W-1:0]     wr_data;
    logic [bffa_pkg::BYTE_W-1:0]     rd_data;
    logic [bffa_pkg::BYTE_W-1:0]     chk_byte;
    bffa_pkg::t_byte_res             byte_res;
    logic [bffa_pkg::LIMIT_W-1:0]    eff_limit;
    logic [bffa_pkg::IDX_W+2:0]      found_item;
    logic                            found_over;
    logic                            free_over;

    bffa_map_ram u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_chk),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Bytes at or above the fill count were never written and hold no items.
    assign chk_byte = (bffa_pkg::FILL_W'(r_chk) >= r_fill) ? bffa_pkg::BYTE_EMPTY : rd_data;

    bffa_byte_unit u_byte_unit (
        .i_byte    (chk_byte),
        .i_bit_sel (r_bidx[bffa_pkg::BIT_SEL_W-1:0]),
        .o_res     (byte_res)
    );

    // The limit never reaches past the end of the map.
    assign eff_limit = ({{(bffa_pkg::CAP_W - bffa_pkg::LIMIT_W){1'b0}}, r_limit}
                        < bffa_pkg::ITEM_CAP) ? r_limit
                                              : bffa_pkg::ITEM_CAP[bffa_pkg::LIMIT_W-1:0];

    assign found_item = {r_chk, byte_res.low_zero};
    assign found_over = bffa_pkg::CAP_W'(found_item) >= bffa_pkg::CAP_W'(eff_limit);
    assign free_over  = bffa_pkg::CAP_W'(r_bidx) >= bffa_pkg::CAP_W'(eff_limit);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_chk    = r_chk;
        n_pend   = r_pend;
        n_bidx   = r_bidx;
        n_fill   = r_fill;
        n_done   = 1'b0;
        n_status = r_status;
        n_aidx   = r_aidx;
        wr_en    = 1'b0;
        wr_data  = byte_res.set_low;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_bidx = i_bit_index;
                    n_pend = 1'b0;
                    if (i_func == bffa_pkg::FUNC_FREE) begin
                        n_addr  = bffa_pkg::IDX_W'(i_bit_index >> 3);
                        n_state = ST_FREE_RD;
                    end else begin
                        n_addr  = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Keep one read in flight; check the byte that came back.
                n_addr = r_addr + bffa_pkg::IDX_W'(1);
                n_chk  = r_addr;
                n_pend = 1'b1;
                if (r_pend && !byte_res.all_ones) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    if (found_over) begin
                        n_status = bffa_pkg::STAT_FULL;
                        n_aidx   = '0;
                    end else begin
                        wr_en    = 1'b1;
                        wr_data  = byte_res.set_low;
                        n_status = bffa_pkg::STAT_OK;
                        n_aidx   = bffa_pkg::INDEX_W'(found_item);
                        if (bffa_pkg::FILL_W'(r_chk) == r_fill) begin
                            n_fill = r_fill + bffa_pkg::FILL_W'(1);
                        end
                    end
                end else if (r_pend && r_chk == bffa_pkg::LAST_BYTE) begin
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = bffa_pkg::STAT_FULL;
                    n_aidx   = '0;
                end
            end
            ST_FREE_RD: begin
                n_chk = r_addr;
                if (free_over) begin
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = bffa_pkg::STAT_RANGE;
                    n_aidx   = '0;
                end else begin
                    n_state = ST_FREE_CHK;
                end
            end
            ST_FREE_CHK: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                n_aidx  = '0;
                if (!byte_res.bit_set) begin
                    n_status = bffa_pkg::STAT_NOT_ALLOC;
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = byte_res.clr_sel;
                    n_status = bffa_pkg::STAT_OK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_fill   <= '0;
            r_limit  <= bffa_pkg::LIMIT_RESET;
            r_done   <= 1'b0;
            r_status <= bffa_pkg::STAT_OK;
            r_aidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_fill   <= n_fill;
            r_done   <= n_done;
            r_status <= n_status;
            r_aidx   <= n_aidx;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // Addresses and the request item need no reset.
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_chk  <= n_chk;
        r_bidx <= n_bidx;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_alloc_index = r_aidx;

    // An accepted request always makes the block busy on the next cycle.
    `BFFA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // A result is shown only once the sequencer is back at idle.
    `BFFA_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // Only a successful allocation returns a nonzero index.
    `BFFA_ASSERT_IMPL(a_index_zero, i_clk, i_rst_n,
        o_done && (o_status != bffa_pkg::STAT_OK), o_alloc_index == '0)
    // The fill count never runs past the end of the map.
    `BFFA_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1,
        r_fill <= bffa_pkg::FILL_W'(bffa_pkg::MAP_BYTES))

endmodule

// ----- sim/bitmap_first_free_allocator_unit_test.sv -----
module bitmap_first_free_allocator_unit_test;
    // Self-checking bench for the first-fit bitmap allocator.
    //
    // Requests go in over the start/busy handshake, and results come back as one-cycle
    // strobes on o_done. The receiver cannot stall them, so every strobe is checked at the
    // edge that ends its cycle. A behavioral copy of the usage map and of the item limit
    // predicts the status and index of every request at the moment the request is accepted.
    // Results are compared in order against that queue of predictions.
    import bffa_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    // The longest correct silence is a long sender gap plus a full map scan.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 72;
    // After the last result, stay long enough to catch a stray strobe from a full scan.
    localparam int SETTLE_CYCLES  = 1100;

    // Row kinds and check modes of the directed plan.
    localparam logic ROW_REQ   = 1'b0;
    localparam logic ROW_CFG   = 1'b1;
    localparam logic CHK_MODEL = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   alloc_index;
    } alloc_result_t;

    // For a configuration row, value is the new item limit. For a request row,
    // its low bits are the item index.
    typedef struct packed {
        logic                 kind;
        t_func                func;
        logic [LIMIT_W-1:0]   value;
        logic                 check;
        alloc_result_t        exp;
    } plan_row_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   start         = 1'b0;
    logic                   busy;
    logic                   i_func        = FUNC_ALLOC;
    logic [INDEX_W-1:0]     i_bit_index   = '0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]     i_cfg_wr_data = '0;
    logic                   o_done;
    logic [STATUS_W-1:0]    o_status;
    logic [INDEX_W-1:0]     o_alloc_index;

    // The bench keeps its own copy of the allocation state, updated in request order.
    logic [BYTE_W-1:0]      shadow_map [MAP_BYTES];
    logic [LIMIT_W-1:0]     shadow_limit = LIMIT_RESET;
    alloc_result_t          pending [$];
    logic [INDEX_W-1:0]     held_items [$];
    alloc_result_t          head_res;
    int                     mismatches  = 0;
    int                     idle_cycles = 0;
    bit                     steady_feed = 1'b0;

    // Directed plan. Rows whose answer is obvious carry it typed in. The rest rely on the
    // predictor. The plan starts at the reset limit, goes above the map size, then to zero,
    // then to a tiny limit that cuts into byte 0, and then back to the reset limit, where it
    // fills byte 0 so that an allocation has to step over a full byte.
    plan_row_t plan [0:28] = '{
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_TYPED, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_TYPED, '{STAT_OK,        13'd1}},
        '{ROW_REQ, FUNC_FREE,  14'd0,     CHK_TYPED, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd0,     CHK_TYPED, '{STAT_NOT_ALLOC, 13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_TYPED, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd8191,  CHK_TYPED, '{STAT_NOT_ALLOC, 13'd0}},
        '{ROW_CFG, FUNC_ALLOC, 14'd16383, CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd8191,  CHK_TYPED, '{STAT_NOT_ALLOC, 13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd1,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_CFG, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_TYPED, '{STAT_FULL,      13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd0,     CHK_TYPED, '{STAT_RANGE,     13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd8191,  CHK_TYPED, '{STAT_RANGE,     13'd0}},
        '{ROW_CFG, FUNC_ALLOC, 14'd2,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_TYPED, '{STAT_OK,        13'd1}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_TYPED, '{STAT_FULL,      13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd2,     CHK_TYPED, '{STAT_RANGE,     13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd1,     CHK_TYPED, '{STAT_OK,        13'd0}},
        '{ROW_CFG, FUNC_ALLOC, LIMIT_RESET, CHK_MODEL, '{STAT_OK,      13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_FREE,  14'd4,     CHK_MODEL, '{STAT_OK,        13'd0}},
        '{ROW_REQ, FUNC_ALLOC, 14'd0,     CHK_MODEL, '{STAT_OK,        13'd0}}
    };

    bitmap_first_free_allocator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_bit_index   (i_bit_index),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_alloc_index (o_alloc_index)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Computes the outcome of one request and applies it to the shadow map. The
    // effective limit never exceeds the number of items that the map can hold.
    // An allocation that finds its lowest clear bit at or above the limit reports
    // full and leaves the map untouched.
    function automatic alloc_result_t predict_request(t_func f, logic [INDEX_W-1:0] idx);
        alloc_result_t res;
        int            eff;
        int            k;
        int            b;
        int            item;
        res.status      = STAT_OK;
        res.alloc_index = '0;
        eff = (int'(shadow_limit) < MAP_ITEMS) ? int'(shadow_limit) : MAP_ITEMS;
        if (f == FUNC_ALLOC) begin
            k = 0;
            while (k < MAP_BYTES && shadow_map[k] == BYTE_FULL) k++;
            if (k >= MAP_BYTES) begin
                res.status = STAT_FULL;
            end else begin
                b = 0;
                while (b < 7 && shadow_map[k][b]) b++;
                item = k * 8 + b;
                if (item >= eff) begin
                    res.status = STAT_FULL;
                end else begin
                    shadow_map[k][b] = 1'b1;
                    res.alloc_index  = INDEX_W'(item);
                end
            end
        end else if (int'(idx) >= eff) begin
            res.status = STAT_RANGE;
        end else if (!shadow_map[idx >> 3][idx[2:0]]) begin
            res.status = STAT_NOT_ALLOC;
        end else begin
            shadow_map[idx >> 3][idx[2:0]] = 1'b0;
        end
        return res;
    endfunction

    // Sender pauses: mostly none or short, now and then long. Some phases run with
    // no pauses at all, so that requests arrive back to back.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [LIMIT_W-1:0] phase_limit(int p);
        case (p)
            0: return LIMIT_RESET;
            1: return LIMIT_W'($urandom_range(1, 64));
            2: return '1;
            3: return LIMIT_W'($urandom_range(0, 16383));
            4: return '0;
            5: return LIMIT_W'($urandom_range(1, 24));
            6: return LIMIT_W'($urandom_range(8193, 16383));
            default: return LIMIT_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Presents one request and holds it until the block accepts it. The request
    // is accepted at the first edge where start is high and busy is low. The
    // prediction is made at that edge, which keeps the shadow state in step with
    // the block. start is left high, so the next request can follow at once.
    task automatic issue_request(input t_func f, input logic [INDEX_W-1:0] idx,
                                 input logic check, input alloc_result_t typed_res,
                                 output alloc_result_t outcome);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= f;
        i_bit_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        outcome = predict_request(f, idx);
        pending.push_back((check == CHK_TYPED) ? typed_res : outcome);
    endtask

    // The limit changes only when the block is idle. Every request yields a result, so
    // an empty queue of predictions means that nothing is still in flight.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_limit = value;
    endtask

    // Result checker and watchdog. The watchdog counts edges at which neither a
    // request nor a result was accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_done) begin
                if (pending.size() == 0) begin
                    $error("unexpected result: status %0d alloc_index %0d",
                           o_status, o_alloc_index);
                    mismatches++;
                end else begin
                    head_res = pending.pop_front();
                    if (o_status !== head_res.status) begin
                        $error("status: expected %0d, actual %0d", head_res.status, o_status);
                        mismatches++;
                    end
                    if (o_alloc_index !== head_res.alloc_index) begin
                        $error("alloc_index: expected %0d, actual %0d",
                               head_res.alloc_index, o_alloc_index);
                        mismatches++;
                    end
                end
            end
            if (o_done || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        alloc_result_t      outcome;
        t_func              f;
        logic [INDEX_W-1:0] idx;
        int                 pick;
        int                 eff;
        foreach (shadow_map[k]) shadow_map[k] = BYTE_EMPTY;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                write_limit(plan[r].value);
            end else begin
                issue_request(plan[r].func, plan[r].value[INDEX_W-1:0], plan[r].check,
                              plan[r].exp, outcome);
            end
        end

        // Take over whatever the directed part left allocated.
        for (int i = 0; i < MAP_ITEMS; i++)
            if (shadow_map[i >> 3][i % 8]) held_items.push_back(INDEX_W'(i));

        // Each random phase uses its own limit. Most traffic is allocations and frees of
        // items that really are held. The rest is frees of arbitrary items, which hit the
        // not-allocated and out-of-range paths. The bit index is random on allocations too,
        // where the block must ignore it.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_limit(phase_limit(p));
            steady_feed = ($urandom_range(0, 3) == 0);
            eff = (int'(shadow_limit) < MAP_ITEMS) ? int'(shadow_limit) : MAP_ITEMS;
            repeat (PHASE_REQUESTS) begin
                pick = $urandom_range(0, 99);
                idx  = INDEX_W'($urandom_range(0, MAP_ITEMS - 1));
                if (pick < 50 || held_items.size() == 0) begin
                    f = FUNC_ALLOC;
                end else if (pick < 85) begin
                    f   = FUNC_FREE;
                    idx = held_items[$urandom_range(0, held_items.size() - 1)];
                end else begin
                    f = FUNC_FREE;
                    if (pick < 93 && eff > 0) idx = INDEX_W'($urandom_range(0, eff - 1));
                end
                issue_request(f, idx, CHK_MODEL, '0, outcome);
                if (outcome.status == STAT_OK) begin
                    if (f == FUNC_ALLOC) begin
                        held_items.push_back(outcome.alloc_index);
                    end else begin
                        for (int j = 0; j < held_items.size(); j++) begin
                            if (held_items[j] == idx) begin
                                held_items.delete(j);
                                break;
                            end
                        end
                    end
                end
            end
        end

        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
